>>> design/record_interning_table_assert.svh
// ---------------------------------------------------------------------------
// record_interning_table assertion macros
// Shared property forms for the interning table checks.
// ---------------------------------------------------------------------------
`ifndef RECORD_INTERNING_TABLE_ASSERT_SVH
`define RECORD_INTERNING_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("record_interning_table: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("record_interning_table: next-cycle check failed");

`endif

>>> design/rit_pkg.sv
// ---------------------------------------------------------------------------
// rit_pkg
// Types and constants shared by the record interning table modules.
// ---------------------------------------------------------------------------
package rit_pkg;

	localparam int NUM_ELEMS     = 4;
	localparam int ELEM_W        = 32;
	localparam int REF_W         = 9;
	localparam int ARITY_W       = 3;
	localparam int DEF_CAPACITY  = 256;
	localparam int DEF_MAX_ARITY = 4;
	localparam int NUM_LANES     = 4;
	localparam int LANE_W        = $clog2(NUM_LANES);

	typedef enum logic {
		ACT_PACK   = 1'b0,
		ACT_UNPACK = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADREF = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} fsm_t;

	typedef logic [NUM_ELEMS-1:0][ELEM_W-1:0] tuple_t;

	// request beat
	typedef struct packed {
		action_t              action;
		logic [ARITY_W-1:0]   tuple_arity;
		logic signed [31:0]   elem0;
		logic signed [31:0]   elem1;
		logic signed [31:0]   elem2;
		logic signed [31:0]   elem3;
		logic [REF_W-1:0]     lookup_ref;
	} req_t;

	// response beat
	typedef struct packed {
		logic [REF_W-1:0]     ref_out;
		logic                 created;
		logic signed [31:0]   out0;
		logic signed [31:0]   out1;
		logic signed [31:0]   out2;
		logic signed [31:0]   out3;
		status_t              status;
	} rsp_t;

	// one stored record
	typedef struct packed {
		tuple_t               tuple;
		logic [ARITY_W-1:0]   arity;
		logic [REF_W-1:0]     lref;
	} entry_t;

	// search key held for the whole scan
	typedef struct packed {
		action_t              action;
		logic [ARITY_W-1:0]   arity;
		tuple_t               tuple;
		logic [REF_W-1:0]     lref;
	} key_t;

	// what one lane found in its current row
	typedef struct packed {
		logic                 hit;
		tuple_t               tuple;
		logic [REF_W-1:0]     lref;
	} lane_res_t;

	// merged outcome of one scanned row
	typedef struct packed {
		logic                 vld;
		logic                 hit;
		logic                 last;
		tuple_t               tuple;
		logic [REF_W-1:0]     lref;
	} scan_res_t;

endpackage

>>> design/rit_lane.sv
// ---------------------------------------------------------------------------
// rit_lane
// One bank of the record store with its own read port and match logic.
// ---------------------------------------------------------------------------
module rit_lane #(
	parameter int CAPACITY = rit_pkg::DEF_CAPACITY,
	localparam int ROWS  = (CAPACITY + rit_pkg::NUM_LANES - 1) / rit_pkg::NUM_LANES,
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [ROW_W-1:0]     wr_row,
	input  rit_pkg::entry_t      wr_entry,
	input  logic                 rd_en,
	input  logic [ROW_W-1:0]     rd_row,
	input  logic                 rd_live,
	input  rit_pkg::key_t        key,
	output rit_pkg::lane_res_t   res
);

	rit_pkg::entry_t mem [ROWS];
	rit_pkg::entry_t rd_s1;
	logic            live_s1;
	logic            match;

	// write one record, read one row
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_entry;
		end
		if (rd_en) begin
			rd_s1 <= mem[rd_row];
		end
	end

	// track whether the read entry is in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
		end else if (rd_en) begin
			live_s1 <= rd_live;
		end
	end

	// compare against the key: tuple for pack, reference for unpack
	always_comb begin
		match = (rd_s1.arity == key.arity);
		if (key.action == rit_pkg::ACT_PACK) begin
			match = match && (rd_s1.tuple == key.tuple);
		end else begin
			match = match && (rd_s1.lref == key.lref);
		end
		res.hit   = live_s1 && match;
		res.tuple = rd_s1.tuple;
		res.lref  = rd_s1.lref;
	end

endmodule

>>> design/rit_merge.sv
// ---------------------------------------------------------------------------
// rit_merge
// Combines the lane results of one row; the lowest lane wins.
// ---------------------------------------------------------------------------
module rit_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld,
	input  logic                 last,
	input  rit_pkg::lane_res_t   lanes [rit_pkg::NUM_LANES],
	output rit_pkg::scan_res_t   res
);

	logic                        any_hit;
	rit_pkg::lane_res_t          pick;
	logic                        vld_q;
	logic                        hit_q;
	logic                        last_q;
	rit_pkg::tuple_t             tuple_q;
	logic [rit_pkg::REF_W-1:0]   lref_q;

	// select the first hitting lane
	always_comb begin
		any_hit = 1'b0;
		pick    = lanes[0];
		for (int l = rit_pkg::NUM_LANES - 1; l >= 0; l--) begin
			if (lanes[l].hit) begin
				any_hit = 1'b1;
				pick    = lanes[l];
			end
		end
	end

	// register row outcome flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			hit_q  <= 1'b0;
			last_q <= 1'b0;
		end else begin
			vld_q  <= vld;
			hit_q  <= vld && any_hit;
			last_q <= vld && last;
		end
	end

	// register the selected record
	always_ff @(posedge clk) begin
		tuple_q <= pick.tuple;
		lref_q  <= pick.lref;
	end

	assign res = '{vld: vld_q, hit: hit_q, last: last_q, tuple: tuple_q, lref: lref_q};

endmodule

>>> design/record_interning_table.sv
// ---------------------------------------------------------------------------
// record_interning_table
// Interns fixed-arity tuples and hands out per-arity references.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one command beat: pack a
//   tuple into a reference or unpack a reference into its tuple. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one beat per command.
//   Records sit in four lane memories; a command reads one row (one record
//   per lane) per cycle and the merge stage picks the first match.
//   A command scans the rows that hold records until a match ends the scan
//   at its row; commands with a bad arity, a null reference or an empty
//   store skip the scan. One command is in flight at a time; req_ready
//   rises the cycle after the response is loaded. The rate is set by the
//   single row read per cycle of the lane memories. Reset empties the
//   store (used count cleared, every arity restarts at reference 1);
//   record contents are not cleared. When the receiver stalls, the response
//   holds in the output register and one further command can be taken and
//   worked on; its result waits until the output is free.
// ---------------------------------------------------------------------------
`include "record_interning_table_assert.svh"

module record_interning_table #(
	parameter int CAPACITY  = rit_pkg::DEF_CAPACITY,
	parameter int MAX_ARITY = rit_pkg::DEF_MAX_ARITY
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  rit_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rit_pkg::rsp_t   rsp
);

	localparam int LANES = rit_pkg::NUM_LANES;
	localparam int LW    = rit_pkg::LANE_W;
	localparam int ROWS  = (CAPACITY + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RC_W  = $clog2(ROWS + 1);
	localparam int CMP_W = RC_W + LW;
	localparam int UW    = $clog2(CAPACITY + 1);
	localparam int AR_W  = (MAX_ARITY > 1) ? $clog2(MAX_ARITY) : 1;
	localparam int NR_W  = rit_pkg::REF_W + 1;

	typedef logic [rit_pkg::NUM_ELEMS-1:0][rit_pkg::ELEM_W-1:0] tuple_in_t;

	rit_pkg::fsm_t          state_q, state_d;
	rit_pkg::key_t          item_q, key_d;
	logic [UW-1:0]          used_q;
	logic [NR_W-1:0]        next_ref_q [MAX_ARITY];
	logic [RC_W-1:0]        row_q;
	logic                   issued_all_q;
	logic                   iss_s1, last_s1;
	rit_pkg::rsp_t          res_q, res_d;
	rit_pkg::rsp_t          rsp_q;
	logic                   rsp_valid_q;

	logic                   acc, bad, skip, iss, last_iss, decide, hit, full, wr_en, load;
	logic [CMP_W-1:0]       rows_used, wr_ext;
	logic [rit_pkg::ARITY_W-1:0] am1;
	logic [AR_W-1:0]        ar_idx;
	logic [NR_W-1:0]        nr;
	logic [LANES-1:0]       live;
	tuple_in_t              req_elems;
	rit_pkg::entry_t        wr_entry;
	rit_pkg::lane_res_t     lane_res [LANES];
	rit_pkg::scan_res_t     sr;

	assign acc = req_valid && req_ready;

	// mask elements past the arity
	always_comb begin
		req_elems = {req.elem3, req.elem2, req.elem1, req.elem0};
		key_d.action = req.action;
		key_d.arity  = req.tuple_arity;
		key_d.lref   = req.lookup_ref;
		for (int k = 0; k < rit_pkg::NUM_ELEMS; k++) begin
			key_d.tuple[k] = (k < 32'(req.tuple_arity)) ? req_elems[k] : '0;
		end
	end

	// decode the held command
	always_comb begin
		bad  = (item_q.arity == '0) || (32'(item_q.arity) > MAX_ARITY);
		skip = bad || (used_q == '0) ||
		       ((item_q.action == rit_pkg::ACT_UNPACK) && (item_q.lref == '0));
		am1    = item_q.arity - rit_pkg::ARITY_W'(1);
		ar_idx = am1[AR_W-1:0];
		nr     = next_ref_q[ar_idx];
		full   = (used_q == UW'(CAPACITY)) || nr[rit_pkg::REF_W];
		rows_used = CMP_W'((CMP_W'(used_q) + CMP_W'(LANES - 1)) >> LW);
		last_iss  = ((CMP_W'(row_q) + CMP_W'(1)) == rows_used);
		wr_ext    = CMP_W'(used_q);
	end

	// mark which lanes of the issued row hold records
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			live[l] = ({row_q, LW'(l)} < CMP_W'(used_q));
		end
	end

	// build the response when the scan settles
	always_comb begin
		hit    = !skip && sr.vld && sr.hit;
		decide = (state_q == rit_pkg::S_SCAN) && (skip || (sr.vld && (sr.hit || sr.last)));
		res_d  = '0;
		wr_en  = 1'b0;
		priority if (bad) begin
			res_d.status = rit_pkg::ST_BADREF;
		end else if (item_q.action == rit_pkg::ACT_PACK) begin
			if (hit) begin
				res_d.ref_out = sr.lref;
				res_d.status  = rit_pkg::ST_OK;
			end else if (full) begin
				res_d.status  = rit_pkg::ST_FULL;
			end else begin
				res_d.ref_out = nr[rit_pkg::REF_W-1:0];
				res_d.created = 1'b1;
				res_d.status  = rit_pkg::ST_OK;
				wr_en         = decide;
			end
		end else if (hit) begin
			res_d.out0   = sr.tuple[0];
			res_d.out1   = sr.tuple[1];
			res_d.out2   = sr.tuple[2];
			res_d.out3   = sr.tuple[3];
			res_d.status = rit_pkg::ST_OK;
		end else begin
			res_d.status = rit_pkg::ST_BADREF;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rit_pkg::S_IDLE: begin
				if (acc) begin
					state_d = rit_pkg::S_SCAN;
				end
			end
			rit_pkg::S_SCAN: begin
				if (decide) begin
					state_d = rit_pkg::S_FIN;
				end
			end
			rit_pkg::S_FIN: begin
				if (load) begin
					state_d = rit_pkg::S_IDLE;
				end
			end
			default: state_d = rit_pkg::S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_ready = (state_q == rit_pkg::S_IDLE);
		iss       = (state_q == rit_pkg::S_SCAN) && !skip && !issued_all_q;
		load      = (state_q == rit_pkg::S_FIN) && (!rsp_valid_q || rsp_ready);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rit_pkg::S_IDLE;
			used_q       <= '0;
			row_q        <= '0;
			issued_all_q <= 1'b0;
			iss_s1       <= 1'b0;
			last_s1      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			for (int a = 0; a < MAX_ARITY; a++) begin
				next_ref_q[a] <= NR_W'(1);
			end
		end else begin
			state_q <= state_d;
			iss_s1  <= iss;
			last_s1 <= iss && last_iss;
			// restart the row walk per command, advance per issue
			if (acc) begin
				row_q        <= '0;
				issued_all_q <= 1'b0;
			end else if (iss) begin
				row_q <= row_q + RC_W'(1);
				if (last_iss) begin
					issued_all_q <= 1'b1;
				end
			end
			// count the new record and its reference
			if (wr_en) begin
				used_q             <= used_q + UW'(1);
				next_ref_q[ar_idx] <= nr + NR_W'(1);
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			item_q <= key_d;
		end
		if (decide) begin
			res_q <= res_d;
		end
		if (load) begin
			rsp_q <= res_q;
		end
	end

	assign wr_entry.tuple = item_q.tuple;
	assign wr_entry.arity = item_q.arity;
	assign wr_entry.lref  = nr[rit_pkg::REF_W-1:0];

	// lane banks: record i lives in lane i mod LANES, row i / LANES
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		rit_lane #(
			.CAPACITY (CAPACITY)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en && (wr_ext[LW-1:0] == LW'(g))),
			.wr_row   (wr_ext[ROW_W+LW-1:LW]),
			.wr_entry (wr_entry),
			.rd_en    (iss),
			.rd_row   (row_q[ROW_W-1:0]),
			.rd_live  (live[g]),
			.key      (item_q),
			.res      (lane_res[g])
		);
	end

	rit_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (iss_s1 && (state_q == rit_pkg::S_SCAN)),
		.last   (last_s1),
		.lanes  (lane_res),
		.res    (sr)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`RIT_ASSERT_NXT(a_used_step, clk, arst_n, wr_en, used_q == $past(used_q) + UW'(1))
	`RIT_ASSERT_IMP(a_wr_room, clk, arst_n, wr_en, used_q < UW'(CAPACITY))
	`RIT_ASSERT_IMP(a_idle_quiet, clk, arst_n, state_q == rit_pkg::S_IDLE, !iss_s1)
	`RIT_ASSERT_IMP(a_created_ok, clk, arst_n, rsp_valid && rsp.created, (rsp.status == rit_pkg::ST_OK) && (rsp.ref_out != '0))

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// record_interning_table testbench
// Drives pack and unpack commands into the interning table over the request
// channel and checks every response beat against a local model of the store.
// A short directed table covers the edge cases. Random traffic follows: it
// mixes fresh tuples, repeats of stored ones and near misses, and it fills
// the store until it reports full. Both channels idle at random.
// ---------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY   = rit_pkg::DEF_CAPACITY;
	localparam int MAX_ARITY  = rit_pkg::DEF_MAX_ARITY;
	localparam int REF_LIMIT  = 511;
	localparam int IDLE_PCT   = 16;
	localparam int NUM_RANDOM = 450;
	localparam int QUIET_LO   = 200;
	localparam int QUIET_HI   = 300;
	localparam int DRAIN_WAIT = 80;
	localparam int STALL_LIMIT = 4000;
	localparam int NUM_DIR    = 19;

	typedef struct {
		rit_pkg::req_t cmd;
		bit            exact;
		rit_pkg::rsp_t want;
	} dir_row_t;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	rit_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	rit_pkg::rsp_t  rsp;

	// local copy of the record store
	rit_pkg::tuple_t             rec_tuple [CAPACITY];
	logic [rit_pkg::ARITY_W-1:0] rec_arity [CAPACITY];
	int                          rec_lref  [CAPACITY];
	int                          rec_count;
	int                          next_lref [MAX_ARITY];

	rit_pkg::rsp_t pending_rsp [$];
	dir_row_t      dir_rows [NUM_DIR];
	int            error_count = 0;
	int            stall_cycles = 0;
	bit            quiet;

	record_interning_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// clock, 2 ns period
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic rit_pkg::req_t mk_cmd(rit_pkg::action_t act, int arity,
			logic [31:0] e0, logic [31:0] e1, logic [31:0] e2, logic [31:0] e3,
			int lref);
		rit_pkg::req_t c;
		c.action      = act;
		c.tuple_arity = arity[rit_pkg::ARITY_W-1:0];
		c.elem0       = e0;
		c.elem1       = e1;
		c.elem2       = e2;
		c.elem3       = e3;
		c.lookup_ref  = lref[rit_pkg::REF_W-1:0];
		return c;
	endfunction

	function automatic rit_pkg::rsp_t mk_rsp(int ref_val, bit made, logic [31:0] o0,
			logic [31:0] o1, logic [31:0] o2, logic [31:0] o3, rit_pkg::status_t st);
		rit_pkg::rsp_t r;
		r.ref_out = ref_val[rit_pkg::REF_W-1:0];
		r.created = made;
		r.out0    = o0;
		r.out1    = o1;
		r.out2    = o2;
		r.out3    = o3;
		r.status  = st;
		return r;
	endfunction

	// compute the response of one command and update the store
	function automatic rit_pkg::rsp_t intern_predict(rit_pkg::req_t cmd);
		rit_pkg::rsp_t   r;
		rit_pkg::tuple_t key;
		int              a;
		int              nr;
		int              i;
		bit              found;
		r     = mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_OK);
		a     = int'(cmd.tuple_arity);
		found = 1'b0;
		key   = '0;
		if (a == 0 || a > MAX_ARITY) begin
			r.status = rit_pkg::ST_BADREF;
		end else if (cmd.action == rit_pkg::ACT_PACK) begin
			// elements past the arity count as zero
			if (a > 0) key[0] = cmd.elem0;
			if (a > 1) key[1] = cmd.elem1;
			if (a > 2) key[2] = cmd.elem2;
			if (a > 3) key[3] = cmd.elem3;
			for (i = 0; i < rec_count; i++) begin
				if (!found && rec_arity[i] == a && rec_tuple[i] == key) begin
					found     = 1'b1;
					r.ref_out = rec_lref[i][rit_pkg::REF_W-1:0];
				end
			end
			if (!found) begin
				nr = next_lref[a-1];
				if (rec_count >= CAPACITY || nr > REF_LIMIT) begin
					r.status = rit_pkg::ST_FULL;
				end else begin
					rec_tuple[rec_count] = key;
					rec_arity[rec_count] = a[rit_pkg::ARITY_W-1:0];
					rec_lref[rec_count]  = nr;
					rec_count++;
					next_lref[a-1] = nr + 1;
					r.ref_out = nr[rit_pkg::REF_W-1:0];
					r.created = 1'b1;
				end
			end
		end else begin
			if (cmd.lookup_ref != 0) begin
				for (i = 0; i < rec_count; i++) begin
					if (!found && rec_arity[i] == a && rec_lref[i] == cmd.lookup_ref) begin
						found  = 1'b1;
						r.out0 = rec_tuple[i][0];
						r.out1 = rec_tuple[i][1];
						r.out2 = rec_tuple[i][2];
						r.out3 = rec_tuple[i][3];
					end
				end
			end
			if (!found) r.status = rit_pkg::ST_BADREF;
		end
		return r;
	endfunction

	// random command, mostly well formed against the current store
	function automatic rit_pkg::req_t rand_cmd();
		rit_pkg::req_t c;
		int   roll;
		int   sub;
		int   idx;
		int   a;
		int   bad;
		int   bitpos;
		c.action      = rit_pkg::ACT_PACK;
		c.tuple_arity = rit_pkg::ARITY_W'($urandom_range(1, MAX_ARITY));
		c.elem0       = $urandom;
		c.elem1       = $urandom;
		c.elem2       = $urandom;
		c.elem3       = $urandom;
		c.lookup_ref  = rit_pkg::REF_W'($urandom_range(0, 511));
		roll = $urandom_range(0, 99);
		sub  = $urandom_range(0, 99);
		bad  = $urandom_range(5, 8);
		if (roll < 80) begin
			if (sub >= 75 && sub < 93 && rec_count > 0) begin
				// repeat a stored tuple, junk beyond its arity
				idx = $urandom_range(0, rec_count - 1);
				a   = int'(rec_arity[idx]);
				c.tuple_arity = rec_arity[idx];
				if (a > 0) c.elem0 = rec_tuple[idx][0];
				if (a > 1) c.elem1 = rec_tuple[idx][1];
				if (a > 2) c.elem2 = rec_tuple[idx][2];
				if (a > 3) c.elem3 = rec_tuple[idx][3];
				// near miss: one bit off
				if (sub >= 88) begin
					bitpos = $urandom_range(0, 31);
					c.elem0[bitpos] = ~c.elem0[bitpos];
				end
			end else if (sub >= 93) begin
				c.tuple_arity = bad[rit_pkg::ARITY_W-1:0];
			end
		end else begin
			c.action = rit_pkg::ACT_UNPACK;
			a = int'(c.tuple_arity);
			if (sub < 70 && next_lref[a-1] > 1) begin
				c.lookup_ref = rit_pkg::REF_W'($urandom_range(1, next_lref[a-1] - 1));
			end else if (sub >= 85 && sub < 92) begin
				c.lookup_ref = '0;
			end else if (sub >= 92) begin
				c.tuple_arity = bad[rit_pkg::ARITY_W-1:0];
			end
		end
		return c;
	endfunction

	// present one request beat and record its expected response on accept
	task automatic send_beat(input rit_pkg::req_t cmd, input bit exact,
			input rit_pkg::rsp_t want);
		rit_pkg::rsp_t predicted;
		bit   lowered;
		lowered = 1'b0;
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			if (!lowered) req_valid <= 1'b0;
			lowered = 1'b1;
			@(negedge clk);
		end
		req       <= cmd;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		predicted = intern_predict(cmd);
		pending_rsp = {pending_rsp, (exact ? want : predicted)};
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	// receiver readiness, changed on the falling edge
	always @(negedge clk) begin
		rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// compare each response beat with the oldest expectation
	always @(posedge clk) begin
		rit_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				error_count++;
				$display("%0t: unexpected response beat, expected none actual %h",
					$time, rsp);
			end else begin
				want = pending_rsp.pop_front();
				check_field("ref_out", 32'(want.ref_out), 32'(rsp.ref_out));
				check_field("created", 32'(want.created), 32'(rsp.created));
				check_field("out0", want.out0, rsp.out0);
				check_field("out1", want.out1, rsp.out1);
				check_field("out2", want.out2, rsp.out2);
				check_field("out3", want.out3, rsp.out3);
				check_field("status", 32'(want.status), 32'(rsp.status));
			end
		end
	end

	// end the run if no beat moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int a;
		int n;
		req_valid    = 1'b0;
		req          = '0;
		arst_n       = 1'b0;
		quiet        = 1'b0;
		rec_count    = 0;
		for (a = 0; a < MAX_ARITY; a++) next_lref[a] = 1;

		// edge cases: empty store, bad arity, extremes, hits, bad references
		dir_rows[0]  = '{mk_cmd(rit_pkg::ACT_UNPACK, 1, '0, '0, '0, '0, 1), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[1]  = '{mk_cmd(rit_pkg::ACT_PACK, 0, 32'h1, 32'h2, 32'h3, 32'h4, 0), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[2]  = '{mk_cmd(rit_pkg::ACT_PACK, 5, '1, '1, '1, '1, 511), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[3]  = '{mk_cmd(rit_pkg::ACT_UNPACK, 7, '1, '1, '1, '1, 511), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[4]  = '{mk_cmd(rit_pkg::ACT_PACK, 1, 32'h80000000, 32'hdeadbeef, '1,
			32'h5, 0), 1'b1, mk_rsp(1, 1'b1, '0, '0, '0, '0, rit_pkg::ST_OK)};
		dir_rows[5]  = '{mk_cmd(rit_pkg::ACT_PACK, 1, 32'h80000000, '0, 32'h1234, '0,
			300), 1'b1, mk_rsp(1, 1'b0, '0, '0, '0, '0, rit_pkg::ST_OK)};
		dir_rows[6]  = '{mk_cmd(rit_pkg::ACT_PACK, 2, 32'h7fffffff, 32'h80000000, '1,
			'1, 0), 1'b1, mk_rsp(1, 1'b1, '0, '0, '0, '0, rit_pkg::ST_OK)};
		dir_rows[7]  = '{mk_cmd(rit_pkg::ACT_PACK, 3, '1, '1, '1, 32'h0, 0), 1'b1,
			mk_rsp(1, 1'b1, '0, '0, '0, '0, rit_pkg::ST_OK)};
		dir_rows[8]  = '{mk_cmd(rit_pkg::ACT_PACK, 4, '0, '0, '0, '0, 0), 1'b1,
			mk_rsp(1, 1'b1, '0, '0, '0, '0, rit_pkg::ST_OK)};
		dir_rows[9]  = '{mk_cmd(rit_pkg::ACT_PACK, 4, '1, '1, '1, '1, 511), 1'b1,
			mk_rsp(2, 1'b1, '0, '0, '0, '0, rit_pkg::ST_OK)};
		dir_rows[10] = '{mk_cmd(rit_pkg::ACT_UNPACK, 1, '1, '1, '1, '1, 1), 1'b1,
			mk_rsp(0, 1'b0, 32'h80000000, '0, '0, '0, rit_pkg::ST_OK)};
		dir_rows[11] = '{mk_cmd(rit_pkg::ACT_UNPACK, 2, '0, '0, '0, '0, 1), 1'b1,
			mk_rsp(0, 1'b0, 32'h7fffffff, 32'h80000000, '0, '0, rit_pkg::ST_OK)};
		dir_rows[12] = '{mk_cmd(rit_pkg::ACT_UNPACK, 1, '0, '0, '0, '0, 0), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[13] = '{mk_cmd(rit_pkg::ACT_UNPACK, 1, '0, '0, '0, '0, 2), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[14] = '{mk_cmd(rit_pkg::ACT_UNPACK, 4, '0, '0, '0, '0, 511), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[15] = '{mk_cmd(rit_pkg::ACT_UNPACK, 3, '0, '0, '0, '0, 256), 1'b1,
			mk_rsp(0, 1'b0, '0, '0, '0, '0, rit_pkg::ST_BADREF)};
		dir_rows[16] = '{mk_cmd(rit_pkg::ACT_PACK, 2, 32'h7fffffff, '0, '1, '1, 0),
			1'b0, '0};
		dir_rows[17] = '{mk_cmd(rit_pkg::ACT_PACK, 3, '1, '1, '1, 32'h55aa55aa, 0),
			1'b0, '0};
		dir_rows[18] = '{mk_cmd(rit_pkg::ACT_UNPACK, 4, '0, '0, '0, '0, 2), 1'b0, '0};

		// hold reset, then release it
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// walk the directed table
		for (n = 0; n < NUM_DIR; n++)
			send_beat(dir_rows[n].cmd, dir_rows[n].exact, dir_rows[n].want);

		// random traffic, with a stretch where neither side idles
		for (n = 0; n < NUM_RANDOM; n++) begin
			quiet = (n >= QUIET_LO && n < QUIET_HI);
			send_beat(rand_cmd(), 1'b0, '0);
		end
		quiet = 1'b0;
		req_valid <= 1'b0;

		// drain outstanding responses, then let the block settle
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/rit_pkg.sv
design/rit_lane.sv
design/rit_merge.sv
design/record_interning_table.sv
dv/testbench.sv
